### hw/rtl/sids_pkg.sv
// sids_pkg: shared types and constants for the sorted id set difference unit.
// No dependencies.
`default_nettype none
package sids_pkg;
  localparam int MaxIdsDefault = 32;
  localparam int IdW = 32;

  typedef enum logic [1:0] {
    KIND_REMOVED   = 2'd0,
    KIND_UNCHANGED = 2'd1,
    KIND_ADDED     = 2'd2
  } kind_t;

  // command from the load side to the merge side
  typedef struct packed {
    logic quiet;
    logic ovf;
  } close_cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_MERGE_RD,
    ST_MERGE_EMIT,
    ST_COPY
  } state_t;
endpackage
`default_nettype wire

### hw/rtl/sids_front.sv
// sids_front: takes ids and closing flags, queues snapshot-close commands.
// Depends on sids_pkg.
`default_nettype none
module sids_front import sids_pkg::*; #(
  parameter int MAX_IDS = MaxIdsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic       last_of_snapshot,
  input  wire logic       empty_snapshot,
  input  wire logic       silent,
  input  wire logic       count_full,
  output logic            append,
  output logic            discard,
  output logic            cmd_valid,
  output close_cmd_t      cmd,
  input  wire logic       cmd_pop
);
  logic       overflow_seen;
  logic       q_valid;
  close_cmd_t q_cmd;

  assign append  = take && !empty_snapshot && !count_full;
  assign discard = take && empty_snapshot;
  assign cmd_valid = q_valid;
  assign cmd = q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      if (cmd_pop) q_valid <= 1'b0;
      if (take) begin
        if (empty_snapshot) begin
          overflow_seen <= 1'b0;
          q_valid <= 1'b1;
          q_cmd <= '{quiet: silent, ovf: 1'b0};
        end else if (last_of_snapshot) begin
          overflow_seen <= 1'b0;
          q_valid <= 1'b1;
          q_cmd <= '{quiet: silent, ovf: overflow_seen | count_full};
        end else if (count_full) begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  a_no_take_while_queued: assert property (@(posedge clk) disable iff (rst)
    q_valid && !cmd_pop |=> q_valid) else $error("close item lost");
  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> q_valid) else $error("pop of empty queue");
  a_append_excl: assert property (@(posedge clk) disable iff (rst)
    !(append && discard)) else $error("append and discard together");
endmodule
`default_nettype wire

### hw/rtl/sids_back.sv
// sids_back: holds both id stores, sorts the new snapshot in place,
// merges it with the stored set and emits events. Depends on sids_pkg.
`default_nettype none
module sids_back import sids_pkg::*; #(
  parameter int MAX_IDS = MaxIdsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              append,
  input  wire logic              discard,
  input  wire logic [IdW-1:0]    user_id,
  output logic                   count_full,
  input  wire logic              cmd_valid,
  input  close_cmd_t             cmd,
  output logic                   cmd_pop,
  output logic                   idle,
  output logic                   strobe,
  output logic [IdW-1:0]         event_id,
  output logic [1:0]             change_kind,
  output logic                   last_event,
  output logic                   overflow
);
  localparam int CW = $clog2(MAX_IDS + 1);
  localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  logic [IdW-1:0] inc_mem [MAX_IDS];
  logic [IdW-1:0] cur_mem [MAX_IDS];

  state_t state, state_next;
  logic [CW-1:0] inc_count, cur_count;
  logic [CW-1:0] k, pos, i, j;
  logic [IdW-1:0] key, rd_a, rd_b;
  logic quiet, ovf;

  assign count_full = (inc_count == CW'(MAX_IDS));
  assign idle = (state == ST_LOAD) && !cmd_valid;

  // write and read addresses for both id stores, from the FSM
  logic           inc_we;
  logic [AW-1:0]  inc_wa, inc_ra, cur_ra;
  logic [IdW-1:0] inc_wd;
  logic           cur_we;
  logic [AW-1:0]  cur_wa;

  logic have_i, have_j;
  assign have_i = i < cur_count;
  assign have_j = j < inc_count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:       if (cmd_valid) state_next = ST_SORT_RD;
      ST_SORT_RD:    state_next = (k >= inc_count) ? (quiet ? ST_COPY : ST_MERGE_RD)
                                                  : ST_SORT_CMP;
      ST_SORT_CMP:   state_next = ST_SORT_PUT;
      ST_SORT_PUT:   state_next = (pos != '0 && rd_a > key) ? ST_SORT_CMP : ST_SORT_RD;
      ST_MERGE_RD:   state_next = (have_i || have_j) ? ST_MERGE_EMIT : ST_COPY;
      ST_MERGE_EMIT: state_next = ST_MERGE_RD;
      ST_COPY:       state_next = (i >= inc_count) ? ST_LOAD : ST_COPY;
      default:       state_next = ST_LOAD;
    endcase
  end

  // merge decision from registered reads
  logic        take_i, take_j;
  kind_t       kind;
  logic [IdW-1:0] ev;
  always_comb begin
    take_i = 1'b0; take_j = 1'b0; kind = KIND_ADDED; ev = rd_b;
    if (have_i && have_j) begin
      if (rd_b == rd_a) begin
        take_i = 1'b1; take_j = 1'b1; kind = KIND_UNCHANGED;
      end else if (rd_b < rd_a) begin
        take_j = 1'b1;
      end else begin
        take_i = 1'b1; kind = KIND_REMOVED; ev = rd_a;
      end
    end else if (have_i) begin
      take_i = 1'b1; kind = KIND_REMOVED; ev = rd_a;
    end else begin
      take_j = 1'b1;
    end
  end

  logic [CW-1:0] i_adv, j_adv;
  assign i_adv = i + CW'(take_i);
  assign j_adv = j + CW'(take_j);

  always_comb begin
    inc_we = 1'b0; inc_wa = inc_count[AW-1:0]; inc_wd = user_id;
    inc_ra = '0; cur_ra = i[AW-1:0];
    cur_we = 1'b0; cur_wa = i[AW-1:0];
    cmd_pop = 1'b0;
    unique case (state)
      ST_LOAD: begin
        inc_we = append;
        cmd_pop = cmd_valid;
      end
      ST_SORT_RD:  inc_ra = k[AW-1:0];
      ST_SORT_CMP: inc_ra = AW'(pos - CW'(1));
      ST_SORT_PUT: begin
        inc_we = 1'b1; inc_wa = pos[AW-1:0];
        if (pos != '0 && rd_a > key) inc_wd = rd_a;
        else inc_wd = key;
      end
      ST_MERGE_RD: inc_ra = j[AW-1:0];
      ST_MERGE_EMIT: ;
      ST_COPY: begin
        inc_ra = i[AW-1:0];
        cur_we = 1'b1;
      end
      default: ;
    endcase
  end

  // copy writes the registered read data, with a registered write enable and address
  logic           copy_we;
  logic [AW-1:0]  copy_wa;
  always_ff @(posedge clk) begin
    if (inc_we) inc_mem[inc_wa] <= inc_wd;
    rd_b <= inc_mem[inc_ra];
    rd_a <= (state == ST_SORT_CMP) ? inc_mem[inc_ra] : cur_mem[cur_ra];
    if (copy_we) cur_mem[copy_wa] <= rd_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      inc_count <= '0; cur_count <= '0;
      strobe <= 1'b0; copy_we <= 1'b0;
      i <= '0; j <= '0; k <= '0; pos <= '0;
    end else begin
      state <= state_next;
      strobe <= 1'b0;
      copy_we <= cur_we && (i < inc_count);
      copy_wa <= cur_wa;
      unique case (state)
        ST_LOAD: begin
          if (discard) inc_count <= '0;
          else if (append) inc_count <= inc_count + CW'(1);
          if (cmd_valid) begin
            quiet <= cmd.quiet; ovf <= cmd.ovf;
            if (discard) inc_count <= '0;
            k <= CW'(1); i <= '0; j <= '0;
          end
        end
        ST_SORT_RD: begin
          pos <= k;
          if (k >= inc_count) begin
            i <= '0; j <= '0;
          end
        end
        ST_SORT_CMP: if (pos == k) key <= rd_b;
        ST_SORT_PUT: begin
          if (pos != '0 && rd_a > key) pos <= pos - CW'(1);
          else k <= k + CW'(1);
        end
        ST_MERGE_RD: if (!(have_i || have_j)) i <= '0;
        ST_MERGE_EMIT: begin
          strobe <= 1'b1;
          event_id <= ev;
          change_kind <= kind;
          overflow <= ovf;
          last_event <= (i_adv >= cur_count) && (j_adv >= inc_count);
          i <= i_adv; j <= j_adv;
        end
        ST_COPY: begin
          i <= i + CW'(1);
          if (i >= inc_count) begin
            cur_count <= inc_count;
            inc_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    inc_count <= CW'(MAX_IDS) && cur_count <= CW'(MAX_IDS))
    else $error("count beyond capacity");
  a_strobe_merge: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_MERGE_EMIT) else $error("stray event");
  a_no_append_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !append) else $error("append while busy");
endmodule
`default_nettype wire

### hw/rtl/sorted_id_set_diff_unit.sv
// Top level: sorted id set difference unit. Ids load at one per cycle, busy low.
// A closing item then holds busy while the close is taken, the new snapshot is
// insertion-sorted in place, the merge emits its events (merge skipped when
// silent), and the ids are copied into the stored set.
// Events are one-cycle strobes and cannot be stalled.
// Reset (rst, synchronous) empties both stores.
`default_nettype none
module sorted_id_set_diff_unit import sids_pkg::*; #(
  parameter int MAX_IDS = MaxIdsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [IdW-1:0]  user_id,
  input  wire logic            last_of_snapshot,
  input  wire logic            empty_snapshot,
  input  wire logic            silent,
  output logic                 strobe,
  output logic [IdW-1:0]       event_id,
  output logic [1:0]           change_kind,
  output logic                 last_event,
  output logic                 overflow
);
  logic take, append, discard, count_full, cmd_valid, cmd_pop, idle;
  close_cmd_t cmd;

  assign busy = !idle;
  assign take = start && !busy;

  sids_front #(.MAX_IDS(MAX_IDS)) u_front (
    .clk, .rst, .take, .last_of_snapshot, .empty_snapshot, .silent,
    .count_full, .append, .discard, .cmd_valid, .cmd, .cmd_pop
  );

  sids_back #(.MAX_IDS(MAX_IDS)) u_back (
    .clk, .rst, .append, .discard, .user_id, .count_full,
    .cmd_valid, .cmd, .cmd_pop, .idle, .strobe, .event_id,
    .change_kind, .last_event, .overflow
  );
endmodule
`default_nettype wire
